// ===== rtl/core/bia_pkg.sv =====
`default_nettype none

package bia_pkg;

  localparam int SLOTS_DEF     = 1024;
  localparam int WORD_BITS_DEF = 64;
  localparam int SLOT_W        = 10;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t           opcode;
    logic [SLOT_W-1:0] slot_to_free;
  } req_t;

  typedef struct packed {
    logic              success;
    logic [SLOT_W-1:0] granted_slot;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_LOCATE,
    ST_RELEASE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/bia_stream_if.sv =====
`default_nettype none

interface bia_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bia_ram.sv =====
`default_nettype none

module bia_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/bia_lowbit.sv =====
`default_nettype none

module bia_lowbit #(
  parameter int WIDTH = 64,
  localparam int IW   = $clog2(WIDTH)
) (
  input  logic [WIDTH-1:0] word,
  output logic             found,
  output logic [IW-1:0]    idx,
  output logic [WIDTH-1:0] onehot
);

  // isolate the lowest set bit, then encode its position
  assign onehot = word & (~word + WIDTH'(1));
  assign found  = |word;

  always_comb begin
    idx = '0;
    for (int i = 0; i < WIDTH; i++) begin
      if (onehot[i]) begin
        idx = idx | IW'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bitmap_index_allocator_unit.sv =====
`default_nettype none

// Channel | Modport | Payload                              | Transfer when
// req     | sink    | opcode, slot_to_free                 | req.valid && req.ready
// rsp     | source  | success, granted_slot                | rsp.valid && rsp.ready
//
// Allocate: the scan reads one bitmap word per cycle through the single RAM read port.
// Allocate with the hint past the last word: result in the cycle after the transfer.
// Release: the word is located by stepping a running base through the shared adder, one
// word per cycle. After reset a clearing pass writes all ones into the bitmap, with
// req.ready low. One item is in flight at a time; req.ready drops while a result stalls.

module bitmap_index_allocator_unit #(
  parameter int SLOTS     = bia_pkg::SLOTS_DEF,
  parameter int WORD_BITS = bia_pkg::WORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  bia_stream_if.sink          req,
  bia_stream_if.source        rsp
);

  localparam int NWORDS = SLOTS / WORD_BITS;
  localparam int USED   = NWORDS * WORD_BITS;
  localparam int IDX_W  = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int HW_W   = $clog2(NWORDS + 1);
  localparam int CNT_W  = $clog2(USED + 1);
  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam int CW     = (CNT_W > bia_pkg::SLOT_W) ? CNT_W : bia_pkg::SLOT_W;

  bia_pkg::state_t state, state_next;

  logic [IDX_W-1:0]           cur_word, cur_word_next;
  logic [CNT_W-1:0]           base, base_next;
  logic [CNT_W-1:0]           hint, hint_next;
  logic [HW_W-1:0]            hint_word, hint_word_next;
  logic [CNT_W-1:0]           hint_base, hint_base_next;
  logic [bia_pkg::SLOT_W-1:0] slot_q, slot_q_next;
  logic                       rsp_valid;
  bia_pkg::rsp_t              rsp_data, result;
  logic                       load;

  logic                       ram_we;
  logic [IDX_W-1:0]           ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0]       ram_wdata, ram_rdata;

  logic                       lb_found;
  logic [BIT_W-1:0]           lb_idx;
  logic [WORD_BITS-1:0]       lb_onehot;

  logic                       accept;
  logic                       last_word;
  logic                       hint_past_end;
  logic                       slot_in_range;
  logic [CNT_W-1:0]           base_step;
  logic [CNT_W-1:0]           granted;
  logic [CW-1:0]              granted_ext;
  logic [CW-1:0]              slot_ext;
  logic                       slot_in_word;
  logic [BIT_W-1:0]           rel_bit;
  logic [WORD_BITS-1:0]       rel_mask;

  bia_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NWORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bia_lowbit #(
    .WIDTH (WORD_BITS)
  ) u_lowbit (
    .word   (ram_rdata),
    .found  (lb_found),
    .idx    (lb_idx),
    .onehot (lb_onehot)
  );

  // Take a new request only once any earlier result is on its way out
  assign req.ready = (state == bia_pkg::ST_IDLE) && (!rsp_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  // Shared step of the running word base: used by both the scan and the release search
  assign base_step     = base + CNT_W'(WORD_BITS);
  assign last_word     = (cur_word == IDX_W'(NWORDS - 1));
  assign hint_past_end = (hint_word >= HW_W'(NWORDS));
  assign slot_in_range = (CW'(req.data.slot_to_free) < CW'(USED));

  assign granted     = base + CNT_W'(lb_idx);
  assign granted_ext = CW'(granted);

  assign slot_ext     = CW'(slot_q);
  assign slot_in_word = (slot_ext < CW'(base_step));
  assign rel_bit      = BIT_W'(slot_ext - CW'(base));
  assign rel_mask     = WORD_BITS'(1) << rel_bit;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      bia_pkg::ST_INIT: begin
        if (last_word) begin
          state_next = bia_pkg::ST_IDLE;
        end
      end
      bia_pkg::ST_IDLE: begin
        if (accept) begin
          if (req.data.opcode == bia_pkg::OP_ALLOC) begin
            if (!hint_past_end) begin
              state_next = bia_pkg::ST_SCAN;
            end
          end else if (slot_in_range) begin
            state_next = bia_pkg::ST_LOCATE;
          end
        end
      end
      bia_pkg::ST_SCAN: begin
        if (lb_found || last_word) begin
          state_next = bia_pkg::ST_IDLE;
        end
      end
      bia_pkg::ST_LOCATE: begin
        if (slot_in_word) begin
          state_next = bia_pkg::ST_RELEASE;
        end
      end
      bia_pkg::ST_RELEASE: begin
        state_next = bia_pkg::ST_IDLE;
      end
      default: begin
        state_next = bia_pkg::ST_INIT;
      end
    endcase
  end

  // Datapath control and register updates
  always_comb begin
    ram_we         = 1'b0;
    ram_waddr      = cur_word;
    ram_wdata      = ram_rdata;
    ram_raddr      = cur_word;
    load           = 1'b0;
    result         = '0;
    cur_word_next  = cur_word;
    base_next      = base;
    hint_next      = hint;
    hint_word_next = hint_word;
    hint_base_next = hint_base;
    slot_q_next    = slot_q;
    unique case (state)
      bia_pkg::ST_INIT: begin
        // clearing pass: mark every slot free
        ram_we        = 1'b1;
        ram_wdata     = '1;
        cur_word_next = last_word ? '0 : cur_word + IDX_W'(1);
      end
      bia_pkg::ST_IDLE: begin
        if (accept) begin
          if (req.data.opcode == bia_pkg::OP_ALLOC) begin
            if (hint_past_end) begin
              load = 1'b1;
            end else begin
              ram_raddr     = IDX_W'(hint_word);
              cur_word_next = IDX_W'(hint_word);
              base_next     = hint_base;
            end
          end else if (slot_in_range) begin
            slot_q_next   = req.data.slot_to_free;
            cur_word_next = '0;
            base_next     = '0;
          end else begin
            load = 1'b1;
          end
        end
      end
      bia_pkg::ST_SCAN: begin
        if (lb_found) begin
          // grant the lowest free slot and clear its bit
          ram_we              = 1'b1;
          ram_wdata           = ram_rdata ^ lb_onehot;
          load                = 1'b1;
          result.success      = 1'b1;
          result.granted_slot = granted_ext[bia_pkg::SLOT_W-1:0];
          hint_next           = granted + CNT_W'(1);
          if (lb_idx == BIT_W'(WORD_BITS - 1)) begin
            hint_word_next = HW_W'(cur_word) + HW_W'(1);
            hint_base_next = base_step;
          end else begin
            hint_word_next = HW_W'(cur_word);
            hint_base_next = base;
          end
        end else if (last_word) begin
          load = 1'b1;
        end else begin
          // advance to the next word, reading it now so the data lands next cycle
          cur_word_next = cur_word + IDX_W'(1);
          base_next     = base_step;
          ram_raddr     = cur_word + IDX_W'(1);
        end
      end
      bia_pkg::ST_LOCATE: begin
        if (!slot_in_word) begin
          cur_word_next = cur_word + IDX_W'(1);
          base_next     = base_step;
        end
      end
      bia_pkg::ST_RELEASE: begin
        ram_we         = 1'b1;
        ram_wdata      = ram_rdata | rel_mask;
        load           = 1'b1;
        result.success = 1'b1;
        if (CW'(hint) > slot_ext) begin
          hint_next      = CNT_W'(slot_q);
          hint_word_next = HW_W'(cur_word);
          hint_base_next = base;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bia_pkg::ST_INIT;
      cur_word  <= '0;
      hint      <= '0;
      hint_word <= '0;
      hint_base <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cur_word  <= cur_word_next;
      hint      <= hint_next;
      hint_word <= hint_word_next;
      hint_base <= hint_base_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    base   <= base_next;
    slot_q <= slot_q_next;
    if (load) begin
      rsp_data <= result;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bia_checker.sv =====
`default_nettype none

module bia_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic                       rsp_success,
  input logic [bia_pkg::SLOT_W-1:0] rsp_granted_slot
);

  // a stalled result stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_success) && $stable(rsp_granted_slot))
    else $error("result payload changed while stalled");

  // no new request is taken while a result is held back
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("request taken while result stalled");

  // reset leaves the block busy clearing, with nothing offered
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !req_ready && !rsp_valid)
    else $error("block active straight after reset");

endmodule

bind bitmap_index_allocator_unit bia_checker u_bia_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_success      (rsp.data.success),
  .rsp_granted_slot (rsp.data.granted_slot)
);

`default_nettype wire
